### rtl/pct_pkg.sv
// Shared types and constants for the protocol counter table.
// Transfer structs for both channels and the token that walks the cell chain.
// No dependencies.
package pct_pkg;

  localparam int TableEntriesDefault = 256;
  localparam int ProtoW              = 16;
  localparam int CountW              = 32;
  localparam int IndexW              = 8;
  localparam int IndexSpan           = 256;

  typedef struct packed {
    logic [ProtoW-1:0] protocol_id;
    logic [CountW-1:0] byte_increment;
    logic [CountW-1:0] packet_increment;
  } pct_in_t;

  typedef struct packed {
    logic [IndexW-1:0] entry_index;
    logic [CountW-1:0] byte_total;
    logic [CountW-1:0] packet_total;
    logic              new_entry;
    logic              table_full;
  } pct_out_t;

  // Query token; done is set by the cell that matched or inserted the key.
  typedef struct packed {
    logic [ProtoW-1:0] protocol_id;
    logic [CountW-1:0] byte_inc;
    logic [CountW-1:0] pkt_inc;
    logic              done;
    logic              new_entry;
    logic [IndexW-1:0] entry_index;
    logic [CountW-1:0] byte_total;
    logic [CountW-1:0] pkt_total;
  } pct_tok_t;

endpackage

### rtl/pct_cell.sv
// One table slot: stored key plus byte and packet totals.
// Matches or inserts the passing query token and hands it on, registered, in the next cycle.
// Depends on pct_pkg.
module pct_cell import pct_pkg::*; #(
  parameter int CntW    = 9,
  parameter int CellIdx = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] used_i,
  input  logic            tok_valid_i,
  input  pct_tok_t        tok_i,
  output logic            tok_valid_o,
  output pct_tok_t        tok_o
);

  localparam logic [CntW-1:0]   MyIdx   = CntW'(CellIdx);
  localparam logic [IndexW-1:0] SlotLow = IndexW'(CellIdx % IndexSpan);

  logic [ProtoW-1:0] proto_q;
  logic [CountW-1:0] byte_q, byte_d;
  logic [CountW-1:0] pkt_q, pkt_d;
  logic              occupied, match, insert;
  logic              tok_valid_q;
  pct_tok_t          tok_q, tok_d;

  assign occupied = used_i > MyIdx;
  assign match    = tok_valid_i && !tok_i.done && occupied && (proto_q == tok_i.protocol_id);
  // slots fill in order, so the first free cell sits at index used
  assign insert   = tok_valid_i && !tok_i.done && !occupied;

  always_comb begin
    byte_d = byte_q + tok_i.byte_inc;
    pkt_d  = pkt_q + tok_i.pkt_inc;
    tok_d  = tok_i;
    if (match) begin
      tok_d.done        = 1'b1;
      tok_d.new_entry   = 1'b0;
      tok_d.entry_index = SlotLow;
      tok_d.byte_total  = byte_d;
      tok_d.pkt_total   = pkt_d;
    end else if (insert) begin
      tok_d.done        = 1'b1;
      tok_d.new_entry   = 1'b1;
      tok_d.entry_index = SlotLow;
      tok_d.byte_total  = tok_i.byte_inc;
      tok_d.pkt_total   = tok_i.pkt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      byte_q <= byte_d;
      pkt_q  <= pkt_d;
    end else if (insert) begin
      proto_q <= tok_i.protocol_id;
      byte_q  <= tok_i.byte_inc;
      pkt_q   <= tok_i.pkt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

### rtl/protocol_counter_table.sv
// Protocol counter table: a chain of TableEntries cells, one slot each.
// A query walks the chain one cell per cycle; done_o pulses when the token has
// passed the last cell and a register; busy stays high until then, so no new
// query starts sooner. The receiver cannot stall; done_o lasts one cycle.
// Reset empties the table (fill count to zero) and cancels any query in flight.
module protocol_counter_table import pct_pkg::*; #(
  parameter int TableEntries = TableEntriesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pct_in_t  in_i,
  output logic     done_o,
  output pct_out_t res_o
);

  localparam int CntW = $clog2(TableEntries + 1);

  logic            busy_q;
  logic            done_q;
  pct_out_t        res_q;
  logic [CntW-1:0] used_q;
  logic            accept;

  logic     tok_valid_w [0:TableEntries];
  pct_tok_t tok_w       [0:TableEntries];

  assign accept = start && !busy_q;

  always_comb begin
    tok_valid_w[0]          = accept;
    tok_w[0].protocol_id    = in_i.protocol_id;
    tok_w[0].byte_inc       = in_i.byte_increment;
    tok_w[0].pkt_inc        = in_i.packet_increment;
    tok_w[0].done           = 1'b0;
    tok_w[0].new_entry      = 1'b0;
    tok_w[0].entry_index    = '0;
    tok_w[0].byte_total     = '0;
    tok_w[0].pkt_total      = '0;
  end

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    pct_cell #(
      .CntW    (CntW),
      .CellIdx (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .used_i      (used_q),
      .tok_valid_i (tok_valid_w[g]),
      .tok_i       (tok_w[g]),
      .tok_valid_o (tok_valid_w[g+1]),
      .tok_o       (tok_w[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      used_q <= '0;
    end else begin
      done_q <= tok_valid_w[TableEntries];
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok_valid_w[TableEntries]) begin
        busy_q <= 1'b0;
      end
      if (tok_valid_w[TableEntries] && tok_w[TableEntries].new_entry) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_w[TableEntries]) begin
      if (tok_w[TableEntries].done) begin
        res_q.entry_index  <= tok_w[TableEntries].entry_index;
        res_q.byte_total   <= tok_w[TableEntries].byte_total;
        res_q.packet_total <= tok_w[TableEntries].pkt_total;
        res_q.new_entry    <= tok_w[TableEntries].new_entry;
        res_q.table_full   <= 1'b0;
      end else begin
        // unmatched key ran off the end: table full
        res_q.entry_index  <= '0;
        res_q.byte_total   <= '0;
        res_q.packet_total <= '0;
        res_q.new_entry    <= 1'b0;
        res_q.table_full   <= 1'b1;
      end
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### verif/tb_protocol_counter_table.sv
// Testbench for protocol_counter_table: drives lookup/update commands and checks
// every result against a scoreboard that tracks the table contents itself.
// Depends on pct_pkg and the protocol_counter_table RTL.
module tb_protocol_counter_table;
  import pct_pkg::*;

  localparam int Slots       = TableEntriesDefault;
  localparam int DrainCycles = Slots + 16;

  class counter_scoreboard;
    logic [ProtoW-1:0] slot_proto [Slots];
    logic [CountW-1:0] slot_bytes [Slots];
    logic [CountW-1:0] slot_pkts  [Slots];
    int unsigned       fill;
    pct_out_t          pending [$];
    int unsigned       errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Apply one accepted command to the table copy and queue its result.
    function void note_request(pct_in_t req);
      pct_out_t    res;
      int unsigned hit_slot;
      bit          hit;
      hit      = 1'b0;
      hit_slot = 0;
      res      = '0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (!hit && slot_proto[i] == req.protocol_id) begin
          hit      = 1'b1;
          hit_slot = i;
        end
      end
      if (hit) begin
        slot_bytes[hit_slot] = slot_bytes[hit_slot] + req.byte_increment;
        slot_pkts[hit_slot]  = slot_pkts[hit_slot] + req.packet_increment;
        res.entry_index  = hit_slot[IndexW-1:0];
        res.byte_total   = slot_bytes[hit_slot];
        res.packet_total = slot_pkts[hit_slot];
      end else if (fill >= Slots) begin
        res.table_full = 1'b1;
      end else begin
        slot_proto[fill] = req.protocol_id;
        slot_bytes[fill] = req.byte_increment;
        slot_pkts[fill]  = req.packet_increment;
        res.entry_index  = fill[IndexW-1:0];
        res.byte_total   = req.byte_increment;
        res.packet_total = req.packet_increment;
        res.new_entry    = 1'b1;
        fill++;
      end
      pending.push_back(res);
    endfunction

    task check_result(pct_out_t got);
      pct_out_t exp;
      if (pending.size() == 0) begin
        report("result transfer with no command outstanding");
      end else begin
        exp = pending.pop_front();
        if (got.entry_index !== exp.entry_index)
          report($sformatf("entry_index got %0d exp %0d", got.entry_index, exp.entry_index));
        if (got.byte_total !== exp.byte_total)
          report($sformatf("byte_total got %h exp %h", got.byte_total, exp.byte_total));
        if (got.packet_total !== exp.packet_total)
          report($sformatf("packet_total got %h exp %h", got.packet_total, exp.packet_total));
        if (got.new_entry !== exp.new_entry)
          report($sformatf("new_entry got %b exp %b", got.new_entry, exp.new_entry));
        if (got.table_full !== exp.table_full)
          report($sformatf("table_full got %b exp %b", got.table_full, exp.table_full));
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pct_in_t  in_i;
  logic     done_o;
  pct_out_t res_o;

  counter_scoreboard sb;
  logic [ProtoW-1:0] sent_protos [$];
  bit                proto_seen [logic [ProtoW-1:0]];

  protocol_counter_table #(
    .TableEntries(Slots)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    if (roll < 96) return $urandom_range(5, 40);
    return $urandom_range(Slots - 8, Slots + 140);
  endfunction

  function automatic logic [CountW-1:0] pick_increment();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 35) return CountW'($urandom_range(1, 2000));
    if (roll < 45) return {1'b1, (CountW-1)'($urandom)};
    return CountW'($urandom);
  endfunction

  task automatic send_cmd(logic [ProtoW-1:0] proto, logic [CountW-1:0] dbytes,
                          logic [CountW-1:0] dpkts, int unsigned gap);
    pct_in_t cmd;
    cmd.protocol_id      = proto;
    cmd.byte_increment   = dbytes;
    cmd.packet_increment = dpkts;
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
      in_i  = $bits(pct_in_t)'({$urandom, $urandom, $urandom});
    end
    @(negedge clk_i);
    start = 1'b1;
    in_i  = cmd;
    do @(posedge clk_i); while (busy);
    sb.note_request(cmd);
    if (!proto_seen.exists(proto)) begin
      proto_seen[proto] = 1'b1;
      sent_protos.push_back(proto);
    end
  endtask

  initial begin
    logic [ProtoW-1:0] proto;
    int unsigned       count;
    sb     = new();
    rst_ni = 1'b0;
    start  = 1'b0;
    in_i   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: key extremes, counter wrap, repeated keys
    send_cmd(16'h0000, 32'h0000_0000, 32'h0000_0000, 0);
    send_cmd(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_cmd(16'hFFFF, 32'h0000_0001, 32'h0000_0001, 0);
    send_cmd(16'h0000, 32'hFFFF_FFFF, 32'h0000_0001, 2);
    send_cmd(16'h0000, 32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_cmd(16'h0800, 32'd1500, 32'd1, 0);
    send_cmd(16'h86DD, 32'd60, 32'd1, 1);
    send_cmd(16'h0806, 32'd42, 32'd1, 0);
    send_cmd(16'h0800, 32'd64, 32'd1, 0);
    send_cmd(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_cmd(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_cmd(16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0);
    send_cmd(16'h0800, 32'h8000_0000, 32'h8000_0000, 3);
    send_cmd(16'h0800, 32'h8000_0000, 32'h8000_0000, 0);
    send_cmd(16'h0001, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_cmd(16'h8000, 32'h7FFF_FFFF, 32'h0000_0000, 0);
    send_cmd(16'h0000, 32'h0000_0000, 32'h0000_0000, 0);

    // random: about half known keys, half fresh ones, so the table fills
    for (count = 0; count < 650; count++) begin
      if (sent_protos.size() != 0 && $urandom_range(0, 99) < 50)
        proto = sent_protos[$urandom_range(0, sent_protos.size() - 1)];
      else
        proto = ProtoW'($urandom);
      send_cmd(proto, pick_increment(), pick_increment(), pick_gap());
    end
    @(negedge clk_i);
    start = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[protocol_counter_table] OK");
    end else begin
      $display("[protocol_counter_table] ERROR");
    end
    $finish;
  end

  initial begin
    #12000000;
    $display("[protocol_counter_table] ERROR");
    $finish;
  end

endmodule
